/* hw/rtl/catmull_rom_curve_flattener_top_defines.svh */
// Assertion macros for the Catmull-Rom curve flattener.
// Included by the top level; expects signals clk and rst in scope.
`ifndef CATMULL_ROM_CURVE_FLATTENER_TOP_DEFINES_SVH
`define CATMULL_ROM_CURVE_FLATTENER_TOP_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define CRCF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CRCF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/crcf_pkg.sv */
// Package for the Catmull-Rom curve flattener.
// Holds default sizes, register constants, state types and control structs.
package crcf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int MAX_RES     = 32;
  localparam int RES_WIDTH   = 6;
  localparam int RES_MIN     = 2;
  localparam logic [RES_WIDTH-1:0] RES_RESET = 6'd16;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQ,
    T_CUBE,
    T_COEF,
    T_KICK,
    T_WAIT,
    T_PUSH
  } top_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MAC,
    E_SIGN,
    E_DIV
  } eval_state_t;

  typedef struct packed {
    logic start;
  } eval_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eval_stat_t;

endpackage

/* hw/rtl/crcf_ifs.sv */
// Valid/ready channel interfaces for the Catmull-Rom curve flattener.
// Depends on crcf_pkg for the default coordinate width.
interface crcf_point_if #(
  parameter int CW = crcf_pkg::COORD_WIDTH
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] pz;
  logic seg_first;
  logic seg_last;

  modport source(output valid, px, py, pz, seg_first, seg_last, input ready);
  modport sink(input valid, px, py, pz, seg_first, seg_last, output ready);
endinterface

interface crcf_sample_if #(
  parameter int CW = crcf_pkg::COORD_WIDTH
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;
  logic signed [CW-1:0] qz;
  logic run_end;

  modport source(output valid, qx, qy, qz, run_end, input ready);
  modport sink(input valid, qx, qy, qz, run_end, output ready);
endinterface

/* hw/rtl/catmull_rom_curve_flattener_top.sv */
// Top level of the Catmull-Rom curve flattener: point window, sample sequencer,
// resolution register and output word register. Depends on crcf_pkg, crcf_ifs and crcf_eval.
// For each sample, the square, cube and coefficient steps build the sample weights, then
// each of the three coordinates in turn passes through the shared evaluator (four
// multiply-accumulate steps and a restoring divider that retires one quotient bit per
// cycle), then a push step hands the word to the output register once it can take it.
// A point yields R samples, with R the resolution clamped to 2..MAX_RES, and 2R samples
// when it ends a curve. Points are accepted only while no sample work is pending, and
// the output register lets the next sample be computed while a finished word waits.
module catmull_rom_curve_flattener_top #(
  parameter int COORD_WIDTH = crcf_pkg::COORD_WIDTH,
  parameter int MAX_RES     = crcf_pkg::MAX_RES
) (
  input  logic                               clk,
  input  logic                               rst,
  crcf_point_if.sink                         points,
  crcf_sample_if.source                      samples,
  input  logic                               cfg_wr_en,
  input  logic [crcf_pkg::RES_WIDTH-1:0]     cfg_wr_data
);

  `include "catmull_rom_curve_flattener_top_defines.svh"

  localparam int CW  = COORD_WIDTH;
  localparam int IW  = $clog2(MAX_RES);
  localparam int SQW = 2 * IW;
  localparam int MW  = 3 * IW;
  localparam int CFW = MW + 5;
  localparam int RSW = crcf_pkg::RES_WIDTH;

  crcf_pkg::top_state_t state, state_next;

  logic [RSW-1:0]       resolution;
  logic [IW-1:0]        d;
  logic [IW-1:0]        idx;
  logic                 second;
  logic [1:0]           coord;
  logic                 out_valid;
  logic signed [CW-1:0] win [3][3];
  logic signed [CW-1:0] p3 [3];
  logic [SQW-1:0]       sq_i;
  logic [SQW-1:0]       sq_d;
  logic [MW-1:0]        m [4];
  logic signed [CFW-1:0] coef [4];
  logic signed [CW-1:0] res [3];
  logic signed [CW-1:0] smp_x;
  logic signed [CW-1:0] smp_y;
  logic signed [CW-1:0] smp_z;
  logic                 smp_end;

  logic [RSW-1:0]        res_clamped;
  logic                  accept;
  logic                  push;
  logic                  span_done;
  logic signed [CFW-1:0] mx [4];
  logic signed [CW-1:0]  ev_pts [4];
  logic signed [CW-1:0]  ev_q;
  crcf_pkg::eval_ctl_t   ctl;
  crcf_pkg::eval_stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= crcf_pkg::RES_RESET;
    end else if (cfg_wr_en) begin
      resolution <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (resolution < RSW'(crcf_pkg::RES_MIN)) begin
      res_clamped = RSW'(crcf_pkg::RES_MIN);
    end else if (resolution > RSW'(MAX_RES)) begin
      res_clamped = RSW'(MAX_RES);
    end else begin
      res_clamped = resolution;
    end
  end

  assign accept    = points.valid && points.ready;
  assign push      = (state == crcf_pkg::T_PUSH) && (!out_valid || samples.ready);
  assign span_done = idx == d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crcf_pkg::T_IDLE;
      d         <= '0;
      idx       <= '0;
      second    <= 1'b0;
      coord     <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          win[c][k] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (accept) begin
        d      <= IW'(res_clamped - RSW'(1));
        idx    <= '0;
        second <= points.seg_last;
        if (points.seg_first) begin
          for (int k = 0; k < 3; k++) begin
            win[0][k] <= points.px;
            win[1][k] <= points.py;
            win[2][k] <= points.pz;
          end
        end
      end
      if (state == crcf_pkg::T_COEF) begin
        coord <= '0;
      end else if ((state == crcf_pkg::T_WAIT) && stat.done) begin
        coord <= coord + 2'd1;
      end
      if (push) begin
        out_valid <= 1'b1;
        if (span_done) begin
          idx    <= '0;
          second <= 1'b0;
          for (int c = 0; c < 3; c++) begin
            win[c][0] <= win[c][1];
            win[c][1] <= win[c][2];
            win[c][2] <= p3[c];
          end
        end else begin
          idx <= idx + IW'(1);
        end
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p3[0] <= points.px;
      p3[1] <= points.py;
      p3[2] <= points.pz;
    end
    if (state == crcf_pkg::T_SQ) begin
      sq_i <= SQW'(idx) * SQW'(idx);
      sq_d <= SQW'(d) * SQW'(d);
    end
    if (state == crcf_pkg::T_CUBE) begin
      m[0] <= MW'(sq_d) * MW'(d);
      m[1] <= MW'(sq_d) * MW'(idx);
      m[2] <= MW'(sq_i) * MW'(d);
      m[3] <= MW'(sq_i) * MW'(idx);
    end
    if (state == crcf_pkg::T_COEF) begin
      coef[0] <= (mx[2] <<< 1) - mx[1] - mx[3];
      coef[1] <= (mx[0] <<< 1) - (mx[2] <<< 2) - mx[2] + (mx[3] <<< 1) + mx[3];
      coef[2] <= mx[1] + (mx[2] <<< 2) - (mx[3] <<< 1) - mx[3];
      coef[3] <= mx[3] - mx[2];
    end
    if ((state == crcf_pkg::T_WAIT) && stat.done) begin
      res[coord] <= ev_q;
    end
    if (push) begin
      smp_x   <= res[0];
      smp_y   <= res[1];
      smp_z   <= res[2];
      smp_end <= span_done && !second;
    end
  end

  // The basis is regrouped as one weight per window point, shared by all three coordinates.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mx[k] = signed'({{(CFW-MW){1'b0}}, m[k]});
    end
    for (int k = 0; k < 3; k++) begin
      ev_pts[k] = win[coord][k];
    end
    ev_pts[3] = p3[coord];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crcf_pkg::T_IDLE: begin
        if (points.valid) begin
          state_next = crcf_pkg::T_SQ;
        end
      end
      crcf_pkg::T_SQ: begin
        state_next = crcf_pkg::T_CUBE;
      end
      crcf_pkg::T_CUBE: begin
        state_next = crcf_pkg::T_COEF;
      end
      crcf_pkg::T_COEF: begin
        state_next = crcf_pkg::T_KICK;
      end
      crcf_pkg::T_KICK: begin
        state_next = crcf_pkg::T_WAIT;
      end
      crcf_pkg::T_WAIT: begin
        if (stat.done) begin
          state_next = (coord == 2'd2) ? crcf_pkg::T_PUSH : crcf_pkg::T_KICK;
        end
      end
      crcf_pkg::T_PUSH: begin
        if (push) begin
          state_next = (span_done && !second) ? crcf_pkg::T_IDLE : crcf_pkg::T_SQ;
        end
      end
    endcase
  end

  assign ctl.start     = state == crcf_pkg::T_KICK;
  assign points.ready  = state == crcf_pkg::T_IDLE;
  assign samples.valid = out_valid;
  assign samples.qx    = smp_x;
  assign samples.qy    = smp_y;
  assign samples.qz    = smp_z;
  assign samples.run_end = smp_end;

  crcf_eval #(
    .CW (CW),
    .IW (IW)
  ) u_eval (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat),
    .pts  (ev_pts),
    .coef (coef),
    .m0   (m[0]),
    .q    (ev_q)
  );

  `CRCF_CHECK(a_eval_owned, stat.busy |-> state == crcf_pkg::T_WAIT, "evaluator busy outside wait")
  `CRCF_CHECK(a_idx_range, idx <= d, "sample index beyond span length")
  `CRCF_CHECK_NEXT(a_hold_word, state == crcf_pkg::T_PUSH && out_valid && !samples.ready, state == crcf_pkg::T_PUSH, "pending word overwritten")

endmodule

/* hw/rtl/crcf_eval.sv */
// Iterative evaluator for one coordinate of one curve sample.
// Multiply-accumulate over four weighted points, then a restoring divider.
// Depends on crcf_pkg for its state type and control structs.
module crcf_eval #(
  parameter int CW = crcf_pkg::COORD_WIDTH,
  parameter int IW = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  crcf_pkg::eval_ctl_t            ctl,
  output crcf_pkg::eval_stat_t           stat,
  input  logic signed [CW-1:0]           pts [4],
  input  logic signed [3*IW+4:0]         coef [4],
  input  logic [3*IW-1:0]                m0,
  output logic signed [CW-1:0]           q
);

  localparam int MW   = 3 * IW;
  localparam int CFW  = MW + 5;
  localparam int PW   = CW + CFW;
  localparam int AW   = PW + 1;
  localparam int QB   = CW - 1;
  localparam int RW   = MW + 1;
  localparam int HW   = AW - QB;
  localparam int CNTW = $clog2(QB);

  crcf_pkg::eval_state_t state, state_next;

  logic [1:0]      j;
  logic [CNTW-1:0] cnt;
  logic            done;
  logic [AW-1:0]   acc;
  logic            neg;
  logic            ovf;
  logic [RW-1:0]   rem;
  logic [QB-1:0]   qsh;

  logic signed [PW-1:0] prod;
  logic [AW-1:0]        acc_next;
  logic [AW-1:0]        mag;
  logic [HW-1:0]        hi;
  logic [RW-1:0]        dvs;
  logic                 ovf_c;
  logic [RW:0]          trial;
  logic [RW:0]          diff;
  logic                 ge;
  logic                 last_step;
  logic [CW-1:0]        qmag;

  assign prod      = pts[j] * coef[j];
  assign acc_next  = acc + {prod[PW-1], prod};
  assign mag       = acc[AW-1] ? ~acc : acc;
  assign hi        = mag[AW-1:QB];
  assign dvs       = {m0, 1'b0};
  assign ovf_c     = hi >= {{(HW-RW){1'b0}}, dvs};
  assign trial     = {rem, qsh[QB-1]};
  assign diff      = trial - {1'b0, dvs};
  assign ge        = trial >= {1'b0, dvs};
  assign last_step = cnt == CNTW'(QB - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crcf_pkg::E_IDLE;
      j     <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == crcf_pkg::E_DIV) && last_step;
      if (state == crcf_pkg::E_MAC) begin
        j <= j + 2'd1;
      end else begin
        j <= '0;
      end
      if (state == crcf_pkg::E_DIV) begin
        cnt <= cnt + CNTW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      crcf_pkg::E_IDLE: begin
        if (ctl.start) begin
          acc <= {{(AW-MW){1'b0}}, m0};
        end
      end
      crcf_pkg::E_MAC: begin
        acc <= acc_next;
      end
      crcf_pkg::E_SIGN: begin
        neg <= acc[AW-1];
        ovf <= ovf_c;
        rem <= hi[RW-1:0];
        qsh <= mag[QB-1:0];
      end
      crcf_pkg::E_DIV: begin
        rem <= ge ? diff[RW-1:0] : trial[RW-1:0];
        qsh <= {qsh[QB-2:0], ge};
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      crcf_pkg::E_IDLE: begin
        if (ctl.start) begin
          state_next = crcf_pkg::E_MAC;
        end
      end
      crcf_pkg::E_MAC: begin
        if (j == 2'd3) begin
          state_next = crcf_pkg::E_SIGN;
        end
      end
      crcf_pkg::E_SIGN: begin
        state_next = crcf_pkg::E_DIV;
      end
      crcf_pkg::E_DIV: begin
        if (last_step) begin
          state_next = crcf_pkg::E_IDLE;
        end
      end
    endcase
  end

  // A negative sum is divided as its complement, and the quotient complemented back,
  // which yields the floor.
  assign qmag = {1'b0, qsh};
  assign q    = ovf ? (neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}})
                    : (neg ? ~qmag : qmag);

  assign stat.busy = state != crcf_pkg::E_IDLE;
  assign stat.done = done;

endmodule

/* tb/catmull_rom_curve_flattener_top_test.sv */
// Self-checking testbench for the Catmull-Rom curve flattener top level.
// Uses crcf_pkg and the channel interfaces in crcf_ifs; predicts every sample word
// with exact integer arithmetic and checks the output stream in order.
module catmull_rom_curve_flattener_top_test;

  localparam int CW = crcf_pkg::COORD_WIDTH;
  localparam int RW = crcf_pkg::RES_WIDTH;
  localparam int CLK_PERIOD = 12;
  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) << (CW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int NUM_PHASES = 9;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic seg_first;
    logic seg_last;
    logic flat;
  } point_t;

  typedef struct packed {
    logic [CW-1:0] qx;
    logic [CW-1:0] qy;
    logic [CW-1:0] qz;
    logic run_end;
  } sample_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [RW-1:0] cfg_wr_data;

  crcf_point_if points_ch();
  crcf_sample_if samples_ch();

  catmull_rom_curve_flattener_top u_top (
    .clk(clk),
    .rst(rst),
    .points(points_ch),
    .samples(samples_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [RW-1:0] resolution_q;
  longint win[3][3];
  sample_t curve_samples[$];
  int wrong_words;
  int send_idle;
  int recv_stall;

  // A row marked flat emits samples that all equal the point itself.
  point_t directed_rows[20] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1},
    '{32'h0001_0000, 32'hffff_0000, COORD_MAX,     1'b0, 1'b0, 1'b0},
    '{COORD_MAX,     COORD_MIN,     32'h0000_0000, 1'b1, 1'b0, 1'b1},
    '{COORD_MIN,     COORD_MAX,     32'hffff_ffff, 1'b0, 1'b0, 1'b0},
    '{COORD_MAX,     COORD_MIN,     32'h0000_0001, 1'b0, 1'b0, 1'b0},
    '{COORD_MIN,     COORD_MAX,     32'h0000_0000, 1'b0, 1'b1, 1'b0},
    '{32'h1234_5678, 32'hedcb_a988, 32'h0000_8000, 1'b1, 1'b1, 1'b1},
    '{32'h0002_0000, 32'h0003_8000, 32'hfffe_0000, 1'b0, 1'b0, 1'b0},
    '{32'hfff0_0000, 32'h0010_0000, 32'h0000_0001, 1'b0, 1'b0, 1'b0},
    '{32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b1, 1'b0, 1'b1},
    '{32'hfffb_0000, 32'h0000_0000, 32'h0a00_0000, 1'b0, 1'b1, 1'b0},
    '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 1'b1, 1'b0, 1'b1},
    '{32'h0180_0000, 32'h0100_0000, 32'h0280_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0200_0000, 32'h0280_0000, 32'h0100_0000, 1'b0, 1'b1, 1'b0},
    '{COORD_MIN,     COORD_MIN,     COORD_MIN,     1'b1, 1'b1, 1'b1},
    '{COORD_MAX,     COORD_MAX,     COORD_MAX,     1'b1, 1'b1, 1'b1},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b1},
    '{COORD_MAX,     COORD_MIN,     COORD_MAX,     1'b0, 1'b0, 1'b0},
    '{COORD_MIN,     COORD_MAX,     COORD_MIN,     1'b0, 1'b0, 1'b0},
    '{COORD_MAX,     COORD_MIN,     COORD_MAX,     1'b0, 1'b1, 1'b0}
  };

  int phase_res[NUM_PHASES] = '{2, 0, 1, 63, 32, 3, 5, 33, 4};
  int phase_items[NUM_PHASES] = '{50, 15, 10, 6, 6, 60, 50, 4, 49};
  idling_t phase_idling[NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                        IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_NONE,
                                        IDLE_BOTH};

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [CW-1:0] span_value(longint p0, longint p1, longint p2,
                                               longint p3, longint i, longint d);
    longint k0, k1, k2, k3, num, den, q;
    k0 = 2 * p1;
    k1 = p2 - p0;
    k2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    k3 = -p0 + 3 * p1 - 3 * p2 + p3;
    num = k0 * d * d * d + k1 * i * d * d + k2 * i * i * d + k3 * i * i * i + d * d * d;
    den = 2 * d * d * d;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[CW-1:0];
  endfunction

  function automatic void flatten_point(point_t pt);
    longint p[3];
    int res, spans, n;
    sample_t s;
    p[0] = longint'($signed(pt.px));
    p[1] = longint'($signed(pt.py));
    p[2] = longint'($signed(pt.pz));
    res = int'(resolution_q);
    if (res < crcf_pkg::RES_MIN) res = crcf_pkg::RES_MIN;
    if (res > crcf_pkg::MAX_RES) res = crcf_pkg::MAX_RES;
    if (pt.seg_first) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) win[c][j] = p[c];
      end
    end
    spans = pt.seg_last ? 2 : 1;
    n = 0;
    for (int sp = 0; sp < spans; sp++) begin
      for (int i = 0; i < res; i++) begin
        if (pt.flat) begin
          s.qx = pt.px;
          s.qy = pt.py;
          s.qz = pt.pz;
        end else begin
          s.qx = span_value(win[0][0], win[0][1], win[0][2], p[0], longint'(i),
                            longint'(res - 1));
          s.qy = span_value(win[1][0], win[1][1], win[1][2], p[1], longint'(i),
                            longint'(res - 1));
          s.qz = span_value(win[2][0], win[2][1], win[2][2], p[2], longint'(i),
                            longint'(res - 1));
        end
        n++;
        s.run_end = (n == spans * res);
        curve_samples = {curve_samples, s};
      end
      for (int c = 0; c < 3; c++) begin
        win[c][0] = win[c][1];
        win[c][1] = win[c][2];
        win[c][2] = p[c];
      end
    end
  endfunction

  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] near);
    case ($urandom_range(0, 11))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return $urandom();
      default: return near + $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    endcase
  endfunction

  function automatic void set_idling(idling_t mode);
    send_idle = (mode == IDLE_SEND) ? 54 : (mode == IDLE_BOTH) ? 12 : 0;
    recv_stall = (mode == IDLE_RECV) ? 54 : (mode == IDLE_BOTH) ? 12 : 0;
  endfunction

  task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, $signed(want), $signed(got));
      wrong_words++;
    end
  endtask

  task automatic send_point(point_t pt);
    while ($urandom_range(99) < send_idle) begin
      points_ch.valid <= 1'b0;
      @(negedge clk);
    end
    points_ch.valid <= 1'b1;
    points_ch.px <= pt.px;
    points_ch.py <= pt.py;
    points_ch.pz <= pt.pz;
    points_ch.seg_first <= pt.seg_first;
    points_ch.seg_last <= pt.seg_last;
    do @(posedge clk); while (!points_ch.ready);
    flatten_point(pt);
    @(negedge clk);
  endtask

  task automatic hold_points();
    points_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (curve_samples.size() != 0) @(negedge clk);
  endtask

  task automatic write_resolution(logic [RW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    resolution_q = value;
  endtask

  always @(negedge clk) samples_ch.ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    sample_t want;
    if (!rst && samples_ch.valid && samples_ch.ready) begin
      if (curve_samples.size() == 0) begin
        $display("%0t: unexpected word x %0d y %0d z %0d run_end %0d", $time,
                 $signed(samples_ch.qx), $signed(samples_ch.qy), $signed(samples_ch.qz),
                 samples_ch.run_end);
        wrong_words++;
      end else begin
        want = curve_samples.pop_front();
        check_field("qx", want.qx, samples_ch.qx);
        check_field("qy", want.qy, samples_ch.qy);
        check_field("qz", want.qz, samples_ch.qz);
        check_field("run_end", CW'(want.run_end), CW'(samples_ch.run_end));
      end
    end
  end

  initial begin
    point_t pt;
    point_t prev;
    int curve_left;
    int pick;
    bit loose;
    rst = 1'b1;
    points_ch.valid = 1'b0;
    points_ch.px = '0;
    points_ch.py = '0;
    points_ch.pz = '0;
    points_ch.seg_first = 1'b0;
    points_ch.seg_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    wrong_words = 0;
    resolution_q = crcf_pkg::RES_RESET;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) win[c][j] = 0;
    end
    set_idling(IDLE_NONE);
    prev = '0;
    pt = '0;
    curve_left = 0;
    loose = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) send_point(directed_rows[n]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      hold_points();
      drain();
      write_resolution(RW'(phase_res[ph]));
      set_idling(phase_idling[ph]);
      for (int n = 0; n < phase_items[ph]; n++) begin
        // Mostly whole curves; some lack a start mark, a few are loose points.
        if (curve_left == 0) begin
          pick = $urandom_range(99);
          loose = (pick >= 90);
          curve_left = loose ? 1 : $urandom_range(1, 6);
          pt.seg_first = (pick < 80) || (loose && $urandom_range(1) == 1);
        end else begin
          pt.seg_first = 1'b0;
        end
        pt.seg_last = loose ? 1'($urandom_range(1)) : (curve_left == 1);
        curve_left--;
        pt.px = pick_coord(prev.px);
        pt.py = pick_coord(prev.py);
        pt.pz = pick_coord(prev.pz);
        pt.flat = 1'b0;
        send_point(pt);
        prev = pt;
        if ($urandom_range(29) == 0) begin
          hold_points();
          drain();
        end
      end
    end

    hold_points();
    drain();
    repeat (400) @(negedge clk);
    if (wrong_words == 0 && curve_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
